@@ rtl/ljsdk_pkg.sv @@
// Shared types, codes and helpers of the Lennard-Jones pair force and energy core.
package ljsdk_pkg;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    VAR_12_4  = 2'd0,
    VAR_9_6   = 2'd1,
    VAR_12_6  = 2'd2,
    VAR_UNSET = 2'd3
  } variant_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_DIST = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  localparam int TYPE_W      = 4;
  localparam int DIST_W      = 32;
  localparam int COEF_W      = 48;
  localparam int RES_W       = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STAGES  = 57;
  localparam int SQRT_STAGES = 28;

  typedef struct packed {
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
    logic signed [COEF_W-1:0] e1;
    logic signed [COEF_W-1:0] e2;
    logic signed [COEF_W-1:0] sh;
  } coef_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    coef_t             coef;
    logic [1:0]        variant;
  } job_t;

  typedef struct packed {
    logic signed [RES_W-1:0] v;
    logic                    f;
  } sub_t;

  // a - b, clamped to the int64 range
  function automatic sub_t sat_sub(logic signed [RES_W-1:0] a, logic signed [RES_W-1:0] b);
    sub_t r;
    logic signed [RES_W-1:0] s;
    s = a - b;
    r.f = (a[RES_W-1] != b[RES_W-1]) && (s[RES_W-1] != a[RES_W-1]);
    if (r.f) begin
      r.v = a[RES_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end else begin
      r.v = s;
    end
    return r;
  endfunction

endpackage

@@ rtl/ljsdk_ram.sv @@
// Generic single write port RAM with a registered read port.
module ljsdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ljsdk_front.sv @@
// Front end: takes items, runs the table clear, writes loads and looks up evaluates.
module ljsdk_front #(
  parameter int NUM_TYPES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [ljsdk_pkg::TYPE_W-1:0]        type_a_i,
  input  logic [ljsdk_pkg::TYPE_W-1:0]        type_b_i,
  input  logic [ljsdk_pkg::DIST_W-1:0]        dist_sq_i,
  input  ljsdk_pkg::coef_t                    coef_i,
  input  logic [1:0]                          variant_i,
  input  logic [ljsdk_pkg::QLEVEL_W-1:0]      level_i,
  output logic                                push_o,
  output ljsdk_pkg::job_t                     job_o
);

  localparam int DEPTH = NUM_TYPES * NUM_TYPES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [CW-1:0]                   clr_cnt_q, clr_cnt_d;
  logic                            clr_busy;
  logic                            accept, is_load, in_range, tbl_we;
  logic [ljsdk_pkg::TYPE_W-1:0]    lo, hi;
  logic [AW-1:0]                   addr;
  logic                            f1_v_q;
  logic [ljsdk_pkg::DIST_W-1:0]    f1_d_q;
  logic                            f1_oor_q;
  ljsdk_pkg::coef_t                coef_rd;
  logic [1:0]                      var_rd;
  logic                            var_we;
  logic [AW-1:0]                   var_waddr;
  logic [1:0]                      var_wdata;

  // variant table is swept to unset after reset
  assign clr_busy  = (clr_cnt_q != CW'(DEPTH));
  assign clr_cnt_d = clr_busy ? clr_cnt_q + CW'(1) : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign in_ready_o = !clr_busy &&
                      ((32'(level_i) + 32'(f1_v_q)) < ljsdk_pkg::QUEUE_DEPTH);
  assign accept   = in_valid_i && in_ready_o;
  assign is_load  = (command_i == ljsdk_pkg::CMD_LOAD);
  assign in_range = (32'(type_a_i) < NUM_TYPES) && (32'(type_b_i) < NUM_TYPES);

  // the table is symmetric: keep one copy under the ordered pair
  assign lo   = (type_a_i < type_b_i) ? type_a_i : type_b_i;
  assign hi   = (type_a_i < type_b_i) ? type_b_i : type_a_i;
  assign addr = AW'(32'(lo) * NUM_TYPES + 32'(hi));

  assign tbl_we    = accept && is_load && in_range;
  assign var_we    = clr_busy || tbl_we;
  assign var_waddr = clr_busy ? clr_cnt_q[AW-1:0] : addr;
  assign var_wdata = clr_busy ? ljsdk_pkg::VAR_UNSET : variant_i;

  ljsdk_ram #(.WIDTH($bits(ljsdk_pkg::coef_t)), .DEPTH(DEPTH)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (addr),
    .wdata_i (coef_i),
    .raddr_i (addr),
    .rdata_o (coef_rd)
  );

  ljsdk_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (var_we),
    .waddr_i (var_waddr),
    .wdata_i (var_wdata),
    .raddr_i (addr),
    .rdata_o (var_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else begin
      f1_v_q <= accept && !is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_d_q   <= dist_sq_i;
      f1_oor_q <= !in_range;
    end
  end

  // out of range types read as zero coefficients, unset variant
  assign push_o          = f1_v_q;
  assign job_o.dist_sq   = f1_d_q;
  assign job_o.coef      = f1_oor_q ? '0 : coef_rd;
  assign job_o.variant   = f1_oor_q ? ljsdk_pkg::VAR_UNSET : var_rd;

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !in_ready_o) else $error("item taken during table clear");
  a_lookup_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f1_v_q |-> $past(!clr_busy)) else $error("lookup overlapped table clear");
`endif

endmodule

@@ rtl/ljsdk_queue.sv @@
// Short FIFO between the lookup front end and the arithmetic back end.
module ljsdk_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  ljsdk_pkg::job_t                data_i,
  input  logic                           pop_i,
  output logic                           valid_o,
  output ljsdk_pkg::job_t                data_o,
  output logic [ljsdk_pkg::QLEVEL_W-1:0] level_o
);

  localparam int DEPTH = ljsdk_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  ljsdk_pkg::job_t                  mem_q [DEPTH];
  logic [PW-1:0]                    wptr_q, rptr_q;
  logic [ljsdk_pkg::QLEVEL_W-1:0]   level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + ljsdk_pkg::QLEVEL_W'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - ljsdk_pkg::QLEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign level_o = level_q;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> level_q < ljsdk_pkg::QLEVEL_W'(DEPTH))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> level_q != '0) else $error("queue underflow");
`endif

endmodule

@@ rtl/ljsdk_mul.sv @@
// Q32.32 power product: partial products registered, sum and saturation after.
module ljsdk_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic        as_i,
  input  logic [63:0] b_i,
  input  logic        bs_i,
  output logic [63:0] p_o,
  output logic        ps_o
);

  logic [63:0]  pll_q, plh_q, phl_q, phh_q;
  logic         s_q;
  logic [127:0] sum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
      plh_q <= 64'(a_i[31:0]) * 64'(b_i[63:32]);
      phl_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      phh_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
      s_q   <= as_i || bs_i;
    end
  end

  assign sum  = {64'd0, pll_q} + {32'd0, plh_q, 32'd0} + {32'd0, phl_q, 32'd0} +
                {phh_q, 64'd0};
  assign ps_o = s_q || (sum[127:96] != '0);
  assign p_o  = ps_o ? '1 : sum[95:32];

endmodule

@@ rtl/ljsdk_term.sv @@
// Coefficient times power term: two registered multiply stages, clamp after.
module ljsdk_term (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [47:0]  c_i,
  input  logic [63:0]         p_i,
  input  logic                ps_i,
  output logic signed [63:0]  t_o,
  output logic                sat_o
);

  logic [47:0]  mag;
  logic [55:0]  p0_q, p1_q, p2_q, p3_q;
  logic         neg1_q, zero1_q, ps1_q;
  logic [111:0] prod_q;
  logic         neg2_q, zero2_q, ps2_q;
  logic [63:0]  v;
  logic         over;

  assign mag = c_i[47] ? 48'(-c_i) : 48'(c_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q    <= 56'(mag[23:0])  * 56'(p_i[31:0]);
      p1_q    <= 56'(mag[23:0])  * 56'(p_i[63:32]);
      p2_q    <= 56'(mag[47:24]) * 56'(p_i[31:0]);
      p3_q    <= 56'(mag[47:24]) * 56'(p_i[63:32]);
      neg1_q  <= c_i[47];
      zero1_q <= (c_i == '0);
      ps1_q   <= ps_i;
      prod_q  <= 112'(p0_q) + {24'd0, p1_q, 32'd0} + {32'd0, p2_q, 24'd0} +
                 {p3_q, 56'd0};
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
      ps2_q   <= ps1_q;
    end
  end

  // result is prod / 2^24; magnitude bound is 2^63 for negative terms
  assign v    = prod_q[87:24];
  assign over = (prod_q[111:88] != '0) ||
                (neg2_q ? (v[63] && (v[62:0] != '0)) : v[63]);
  assign sat_o = !zero2_q && (ps2_q || over);

  always_comb begin
    if (zero2_q) begin
      t_o = '0;
    end else if (sat_o) begin
      t_o = neg2_q ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      t_o = neg2_q ? -$signed(v) : $signed(v);
    end
  end

endmodule

@@ rtl/ljsdk_back.sv @@
// Back end: reciprocal and root pipelines, power products, terms and output stage.
module ljsdk_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  ljsdk_pkg::job_t               in_job_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [63:0]            force_o,
  output logic signed [63:0]            energy_o,
  output logic [1:0]                    status_o
);

  localparam int NDS = ljsdk_pkg::DIV_STAGES;
  localparam int NSQ = ljsdk_pkg::SQRT_STAGES;
  localparam int LAT = NDS + 9 + 1 + 2 + 1 + 1 + 1;

  typedef struct packed {
    logic [31:0]     rem;
    logic [56:0]     q;
    logic [30:0]     srem;
    logic [27:0]     root;
    ljsdk_pkg::job_t job;
  } rstg_t;

  typedef struct packed {
    ljsdk_pkg::job_t job;
    logic            zd;
    logic [63:0]     rr, p2, p3, p4, p6, p8, p9, p11, p12, p14;
    logic            s3, s4, s6, s8, s9, s11, s12, s14;
  } pw_t;

  typedef struct packed {
    logic [1:0]         variant;
    logic signed [47:0] sh;
    logic               zd;
  } side_t;

  typedef struct packed {
    logic signed [47:0] c1, c2, e1, e2;
    logic [63:0]        q1, q2, q3, q4;
    logic               s1, s2, s3, s4;
    side_t              side;
  } sel_t;

  typedef struct packed {
    logic signed [63:0] t1, t2, t3, t4;
    logic               f1, f2, f3, f4;
    side_t              side;
  } fin_t;

  typedef struct packed {
    logic signed [63:0] frc;
    logic signed [63:0] eng;
    logic               flag;
    side_t              side;
  } sub_stg_t;

  typedef struct packed {
    logic signed [63:0] frc;
    logic signed [63:0] eng;
    logic [1:0]         status;
  } out_t;

  logic               adv;
  logic [LAT-1:0]     v_q;
  rstg_t              r_prev [NDS];
  rstg_t              r_d    [NDS];
  rstg_t              r_q    [NDS];
  logic [30:0]        sq_rem [NDS];
  logic [27:0]        sq_root[NDS];
  rstg_t              r_init;
  pw_t                pw_q [9];
  pw_t                pw_d0, pw_d2, pw_d4, pw_d6, pw_d8;
  logic [63:0]        m4_p, m6_p, m8_p, m3_p, m12_p, m9_p, m14_p, m11_p;
  logic               m4_s, m6_s, m8_s, m3_s, m12_s, m9_s, m14_s, m11_s;
  sel_t               sel_d, sel_q;
  side_t              dl1_q, dl2_q;
  fin_t               fin_d, fin_q;
  sub_stg_t           sub_d, sub_q;
  ljsdk_pkg::sub_t    fs, es, ss;
  out_t               out_d, out_q;
  logic signed [63:0] tv [4];
  logic [3:0]         tf;

  // whole pipeline moves together; the last stage doubles as output register
  assign adv   = !v_q[LAT-1] || out_ready_i;
  assign pop_o = adv && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[LAT-2:0], in_valid_i};
    end
  end

  // ---- restoring divide of 2^56 by dist_sq, with digit root of dist_sq*2^24
  always_comb begin
    r_init      = '0;
    r_init.job  = in_job_i;
  end

  for (genvar i = 0; i < NDS; i++) begin : g_rdiv
    if (i == 0) begin : g_first
      assign r_prev[i] = r_init;
    end else begin : g_next
      assign r_prev[i] = r_q[i-1];
    end

    if (i < NSQ) begin : g_sqrt
      localparam int K = NSQ - 1 - i;
      always_comb begin
        logic [55:0] n;
        logic [30:0] tr;
        logic [30:0] trial;
        n     = {r_prev[i].job.dist_sq, 24'd0};
        tr    = {r_prev[i].srem[28:0], n[2*K+1 -: 2]};
        trial = {1'b0, r_prev[i].root, 2'b01};
        if (tr >= trial) begin
          sq_rem[i]  = tr - trial;
          sq_root[i] = {r_prev[i].root[26:0], 1'b1};
        end else begin
          sq_rem[i]  = tr;
          sq_root[i] = {r_prev[i].root[26:0], 1'b0};
        end
      end
    end else begin : g_hold
      assign sq_rem[i]  = r_prev[i].srem;
      assign sq_root[i] = r_prev[i].root;
    end

    always_comb begin
      logic [32:0] t;
      logic [32:0] dd;
      t  = {r_prev[i].rem, 1'(i == 0)};
      dd = {1'b0, r_prev[i].job.dist_sq};
      r_d[i]      = r_prev[i];
      r_d[i].srem = sq_rem[i];
      r_d[i].root = sq_root[i];
      if (t >= dd) begin
        r_d[i].rem = 32'(t - dd);
        r_d[i].q   = {r_prev[i].q[55:0], 1'b1};
      end else begin
        r_d[i].rem = t[31:0];
        r_d[i].q   = {r_prev[i].q[55:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_q[i] <= r_d[i];
      end
    end
  end

  // ---- power products, two stages per level
  always_comb begin
    pw_d0     = '0;
    pw_d0.job = r_q[NDS-1].job;
    pw_d0.zd  = (r_q[NDS-1].job.dist_sq == '0);
    pw_d0.p2  = 64'(r_q[NDS-1].q);
    pw_d0.rr  = 64'({r_q[NDS-1].root, 8'd0});
  end

  ljsdk_mul u_m4 (.clk_i(clk_i), .en_i(adv), .a_i(pw_q[0].p2), .as_i(pw_q[0].zd),
    .b_i(pw_q[0].p2), .bs_i(pw_q[0].zd), .p_o(m4_p), .ps_o(m4_s));
  ljsdk_mul u_m6 (.clk_i(clk_i), .en_i(adv), .a_i(pw_q[2].p4), .as_i(pw_q[2].s4),
    .b_i(pw_q[2].p2), .bs_i(pw_q[2].zd), .p_o(m6_p), .ps_o(m6_s));
  ljsdk_mul u_m8 (.clk_i(clk_i), .en_i(adv), .a_i(pw_q[2].p4), .as_i(pw_q[2].s4),
    .b_i(pw_q[2].p4), .bs_i(pw_q[2].s4), .p_o(m8_p), .ps_o(m8_s));
  ljsdk_mul u_m3 (.clk_i(clk_i), .en_i(adv), .a_i(pw_q[2].p4), .as_i(pw_q[2].s4),
    .b_i(pw_q[2].rr), .bs_i(pw_q[2].zd), .p_o(m3_p), .ps_o(m3_s));
  ljsdk_mul u_m12 (.clk_i(clk_i), .en_i(adv), .a_i(pw_q[4].p6), .as_i(pw_q[4].s6),
    .b_i(pw_q[4].p6), .bs_i(pw_q[4].s6), .p_o(m12_p), .ps_o(m12_s));
  ljsdk_mul u_m9 (.clk_i(clk_i), .en_i(adv), .a_i(pw_q[4].p6), .as_i(pw_q[4].s6),
    .b_i(pw_q[4].p3), .bs_i(pw_q[4].s3), .p_o(m9_p), .ps_o(m9_s));
  ljsdk_mul u_m14 (.clk_i(clk_i), .en_i(adv), .a_i(pw_q[6].p12), .as_i(pw_q[6].s12),
    .b_i(pw_q[6].p2), .bs_i(pw_q[6].zd), .p_o(m14_p), .ps_o(m14_s));
  ljsdk_mul u_m11 (.clk_i(clk_i), .en_i(adv), .a_i(pw_q[6].p9), .as_i(pw_q[6].s9),
    .b_i(pw_q[6].p2), .bs_i(pw_q[6].zd), .p_o(m11_p), .ps_o(m11_s));

  always_comb begin
    pw_d2     = pw_q[1];
    pw_d2.p4  = m4_p;
    pw_d2.s4  = m4_s;
  end

  always_comb begin
    pw_d4     = pw_q[3];
    pw_d4.p6  = m6_p;
    pw_d4.s6  = m6_s;
    pw_d4.p8  = m8_p;
    pw_d4.s8  = m8_s;
    pw_d4.p3  = m3_p;
    pw_d4.s3  = m3_s;
  end

  always_comb begin
    pw_d6     = pw_q[5];
    pw_d6.p12 = m12_p;
    pw_d6.s12 = m12_s;
    pw_d6.p9  = m9_p;
    pw_d6.s9  = m9_s;
  end

  always_comb begin
    pw_d8     = pw_q[7];
    pw_d8.p14 = m14_p;
    pw_d8.s14 = m14_s;
    pw_d8.p11 = m11_p;
    pw_d8.s11 = m11_s;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pw_q[0] <= pw_d0;
      pw_q[1] <= pw_q[0];
      pw_q[2] <= pw_d2;
      pw_q[3] <= pw_q[2];
      pw_q[4] <= pw_d4;
      pw_q[5] <= pw_q[4];
      pw_q[6] <= pw_d6;
      pw_q[7] <= pw_q[6];
      pw_q[8] <= pw_d8;
    end
  end

  // ---- pick the powers for the variant
  always_comb begin
    sel_d.c1           = pw_q[8].job.coef.c1;
    sel_d.c2           = pw_q[8].job.coef.c2;
    sel_d.e1           = pw_q[8].job.coef.e1;
    sel_d.e2           = pw_q[8].job.coef.e2;
    sel_d.side.variant = pw_q[8].job.variant;
    sel_d.side.sh      = pw_q[8].job.coef.sh;
    sel_d.side.zd      = pw_q[8].zd;
    unique case (ljsdk_pkg::variant_e'(pw_q[8].job.variant))
      ljsdk_pkg::VAR_12_4: begin
        sel_d.q1 = pw_q[8].p14; sel_d.s1 = pw_q[8].s14;
        sel_d.q2 = pw_q[8].p6;  sel_d.s2 = pw_q[8].s6;
        sel_d.q3 = pw_q[8].p12; sel_d.s3 = pw_q[8].s12;
        sel_d.q4 = pw_q[8].p4;  sel_d.s4 = pw_q[8].s4;
      end
      ljsdk_pkg::VAR_9_6: begin
        sel_d.q1 = pw_q[8].p11; sel_d.s1 = pw_q[8].s11;
        sel_d.q2 = pw_q[8].p8;  sel_d.s2 = pw_q[8].s8;
        sel_d.q3 = pw_q[8].p9;  sel_d.s3 = pw_q[8].s9;
        sel_d.q4 = pw_q[8].p6;  sel_d.s4 = pw_q[8].s6;
      end
      ljsdk_pkg::VAR_12_6, ljsdk_pkg::VAR_UNSET: begin
        sel_d.q1 = pw_q[8].p14; sel_d.s1 = pw_q[8].s14;
        sel_d.q2 = pw_q[8].p8;  sel_d.s2 = pw_q[8].s8;
        sel_d.q3 = pw_q[8].p12; sel_d.s3 = pw_q[8].s12;
        sel_d.q4 = pw_q[8].p6;  sel_d.s4 = pw_q[8].s6;
      end
      default: begin
        sel_d.q1 = '0; sel_d.s1 = 1'b0;
        sel_d.q2 = '0; sel_d.s2 = 1'b0;
        sel_d.q3 = '0; sel_d.s3 = 1'b0;
        sel_d.q4 = '0; sel_d.s4 = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sel_q <= sel_d;
      dl1_q <= sel_q.side;
      dl2_q <= dl1_q;
    end
  end

  // ---- the four terms
  ljsdk_term u_t1 (.clk_i(clk_i), .en_i(adv), .c_i(sel_q.c1), .p_i(sel_q.q1),
    .ps_i(sel_q.s1), .t_o(tv[0]), .sat_o(tf[0]));
  ljsdk_term u_t2 (.clk_i(clk_i), .en_i(adv), .c_i(sel_q.c2), .p_i(sel_q.q2),
    .ps_i(sel_q.s2), .t_o(tv[1]), .sat_o(tf[1]));
  ljsdk_term u_t3 (.clk_i(clk_i), .en_i(adv), .c_i(sel_q.e1), .p_i(sel_q.q3),
    .ps_i(sel_q.s3), .t_o(tv[2]), .sat_o(tf[2]));
  ljsdk_term u_t4 (.clk_i(clk_i), .en_i(adv), .c_i(sel_q.e2), .p_i(sel_q.q4),
    .ps_i(sel_q.s4), .t_o(tv[3]), .sat_o(tf[3]));

  always_comb begin
    fin_d.t1   = tv[0];
    fin_d.t2   = tv[1];
    fin_d.t3   = tv[2];
    fin_d.t4   = tv[3];
    fin_d.f1   = tf[0];
    fin_d.f2   = tf[1];
    fin_d.f3   = tf[2];
    fin_d.f4   = tf[3];
    fin_d.side = dl2_q;
  end

  // ---- differences; energy terms do not count for an unset entry
  always_comb begin
    logic unset;
    unset      = (fin_q.side.variant == ljsdk_pkg::VAR_UNSET);
    fs         = ljsdk_pkg::sat_sub(fin_q.t1, fin_q.t2);
    es         = ljsdk_pkg::sat_sub(fin_q.t3, fin_q.t4);
    sub_d.frc  = fs.v;
    sub_d.eng  = unset ? '0 : es.v;
    sub_d.flag = fin_q.f1 || fin_q.f2 || fs.f ||
                 (!unset && (fin_q.f3 || fin_q.f4 || es.f));
    sub_d.side = fin_q.side;
  end

  always_comb begin
    logic signed [63:0] sh64;
    logic               flag;
    sh64      = {{8{sub_q.side.sh[47]}}, sub_q.side.sh, 8'd0};
    ss        = ljsdk_pkg::sat_sub(sub_q.eng, sh64);
    out_d.frc = sub_q.frc;
    flag      = sub_q.flag;
    if (sub_q.side.variant != ljsdk_pkg::VAR_UNSET) begin
      out_d.eng = ss.v;
      flag      = flag || ss.f;
    end else begin
      out_d.eng = sub_q.eng;
    end
    priority if (sub_q.side.zd) begin
      out_d.status = ljsdk_pkg::ST_ZERO_DIST;
    end else if (flag) begin
      out_d.status = ljsdk_pkg::ST_SATURATED;
    end else begin
      out_d.status = ljsdk_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_q <= fin_d;
      sub_q <= sub_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[LAT-1];
  assign force_o     = out_q.frc;
  assign energy_o    = out_q.eng;
  assign status_o    = out_q.status;

`ifndef SYNTHESIS
  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_q))
    else $error("pending result lost while stalled");
`endif

endmodule

@@ rtl/lj_sdk_pair_force_energy_core.sv @@
// Top level of the Lennard-Jones 12-4 / 9-6 / 12-6 pair force and energy core.
// One item is accepted per clock when s_axis_tready is high; it drops while the
// queue has no room. A load writes the coefficients of a type pair into a symmetric
// table and gives no result; an evaluate returns force over r, pair energy and
// status after the table lookup register, the queue, and then 72 back-end stages
// set mostly by the 57-step pipelined reciprocal of dist_sq. After reset the
// variant table is cleared, during which s_axis_tready is low.
module lj_sdk_pair_force_energy_core #(
  parameter int NUM_TYPES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // type_a, type_b, dist_sq, force_coef_rep, force_coef_att, energy_coef_rep,
  // energy_coef_att, energy_shift, variant, zero pad
  input  logic [287:0]  s_axis_tdata,
  // command
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // force_over_r, pair_energy, status, zero pad
  output logic [135:0]  m_axis_tdata
);

  ljsdk_pkg::coef_t                    coef;
  ljsdk_pkg::job_t                     f_job, q_job;
  logic                                f_push, q_valid, q_pop;
  logic [ljsdk_pkg::QLEVEL_W-1:0]      q_level;
  logic signed [63:0]                  force_over_r, pair_energy;
  logic [1:0]                          status;

  assign coef.c1 = s_axis_tdata[87:40];
  assign coef.c2 = s_axis_tdata[135:88];
  assign coef.e1 = s_axis_tdata[183:136];
  assign coef.e2 = s_axis_tdata[231:184];
  assign coef.sh = s_axis_tdata[279:232];

  ljsdk_front #(.NUM_TYPES(NUM_TYPES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .command_i  (s_axis_tuser[0]),
    .type_a_i   (s_axis_tdata[3:0]),
    .type_b_i   (s_axis_tdata[7:4]),
    .dist_sq_i  (s_axis_tdata[39:8]),
    .coef_i     (coef),
    .variant_i  (s_axis_tdata[281:280]),
    .level_i    (q_level),
    .push_o     (f_push),
    .job_o      (f_job)
  );

  ljsdk_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_job),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_job),
    .level_o (q_level)
  );

  ljsdk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_job_i    (q_job),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .force_o     (force_over_r),
    .energy_o    (pair_energy),
    .status_o    (status)
  );

  assign m_axis_tdata = {6'd0, status, pair_energy, force_over_r};

endmodule
